// ----- hdl/ssharp_pkg.sv -----
// Shared types, constants and saturating byte helpers for the 3x3 sharpen stencil.
package ssharp_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 16;
	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int MIN_DIM    = 3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [ROW_W-1:0] row_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// position and flags that travel with each pixel
	typedef struct packed {
		logic emit;
		logic last;
		row_t row;
		col_t col;
	} tag_t;

	typedef pix_t [8:0] win_t;

	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	function automatic pix_t sat_sub(input pix_t a, input pix_t b);
		return (a > b) ? pix_t'(a - b) : '0;
	endfunction

	function automatic pix_t sat_add(input pix_t a, input pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PIX_W] ? '1 : s[PIX_W-1:0];
	endfunction

endpackage

// ----- hdl/ssharp_window.sv -----
// Line buffer memory and 3x3 window shift register.
module ssharp_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              adv,
	input  ssharp_pkg::pix_t  pixel,
	input  ssharp_pkg::tag_t  tag,
	output logic              valid_s2,
	output ssharp_pkg::tag_t  tag_s2,
	output ssharp_pkg::win_t  win_q
);

	ssharp_pkg::line_t mem [ssharp_pkg::MAX_WIDTH];
	ssharp_pkg::line_t rd_s1;
	ssharp_pkg::pix_t  pixel_s1;
	ssharp_pkg::tag_t  tag_s1;
	logic              valid_s1;

	// read on transfer, write back {old middle, new pixel} from the s1 registers
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[tag.col];
		end
		if (adv && valid_s1) begin
			mem[tag_s1.col] <= '{upper: rd_s1.middle, middle: pixel_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pixel_s1 <= pixel;
			tag_s1   <= tag;
		end
		if (adv && valid_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_s1.upper;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_s1.middle;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= pixel_s1;
			tag_s2   <= tag_s1;
		end
	end

endmodule

// ----- hdl/ssharp_core.sv -----
// Saturating sharpen arithmetic in two stages, ending in the output register.
module ssharp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              valid_s2,
	input  ssharp_pkg::tag_t  tag_s2,
	input  ssharp_pkg::win_t  win_q,
	output logic              out_valid,
	output ssharp_pkg::pix_t  pixel_out,
	output ssharp_pkg::row_t  out_row,
	output ssharp_pkg::col_t  out_col,
	output logic              frame_last
);

	ssharp_pkg::pix_t       v_first;
	ssharp_pkg::pix_t       v_second;
	ssharp_pkg::pix_t       v_s3;
	ssharp_pkg::pix_t       m_s3;
	ssharp_pkg::pix_t [3:0] nb_s3;
	ssharp_pkg::tag_t       tag_s3;
	logic                   valid_s3;

	// top row and mid-left
	always_comb begin
		v_first = win_q[4];
		for (int k = 0; k < 4; k++) begin
			v_first = ssharp_pkg::sat_add(ssharp_pkg::sat_sub(v_first, win_q[k]), win_q[4]);
		end
	end

	// mid-right and bottom row, no add after the last
	always_comb begin
		v_second = v_s3;
		for (int k = 0; k < 3; k++) begin
			v_second = ssharp_pkg::sat_add(ssharp_pkg::sat_sub(v_second, nb_s3[k]), m_s3);
		end
		v_second = ssharp_pkg::sat_sub(v_second, nb_s3[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			valid_s3  <= valid_s2 && tag_s2.emit;
			out_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s3       <= v_first;
			m_s3       <= win_q[4];
			nb_s3      <= {win_q[8], win_q[7], win_q[6], win_q[5]};
			tag_s3     <= tag_s2;
			pixel_out  <= v_second;
			out_row    <= tag_s3.row;
			out_col    <= tag_s3.col;
			frame_last <= tag_s3.last;
		end
	end

endmodule

// ----- hdl/saturating_sharpen_stencil_3x3.sv -----
// Top level: handshakes, configuration registers, raster counters.
// Results pass the s1, window, s3 and output registers after the window's last pixel.
// Throughput: one pixel per cycle; a stalled output holds the whole pipeline.
// Line buffers: one 2048 x 16 memory, read on transfer, written when s1 advances.
// Reset: counters to zero, width 640, height 480; line buffers are not cleared.
module saturating_sharpen_stencil_3x3 (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            pixel_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [7:0]                            pixel_out,
	output logic [15:0]                           out_row,
	output logic [10:0]                           out_col,
	output logic                                  frame_last,
	input  logic                                  cfg_we,
	input  logic [ssharp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssharp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic              adv;
	logic              acc;
	ssharp_pkg::col_t  col_q;
	ssharp_pkg::row_t  row_q;
	ssharp_pkg::col_t  wlast_q;
	ssharp_pkg::row_t  hlast_q;
	ssharp_pkg::tag_t  tag;
	logic              valid_s2;
	ssharp_pkg::tag_t  tag_s2;
	ssharp_pkg::win_t  win_q;
	logic [ssharp_pkg::FW_W-1:0] fw;
	ssharp_pkg::col_t  wlast_new;
	ssharp_pkg::row_t  hlast_new;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign acc      = in_valid && adv;

	always_comb begin
		tag.emit = (row_q >= ssharp_pkg::ROW_W'(2)) && (col_q >= ssharp_pkg::COL_W'(2));
		tag.last = (row_q == hlast_q) && (col_q == wlast_q);
		tag.row  = row_q - ssharp_pkg::ROW_W'(1);
		tag.col  = col_q - ssharp_pkg::COL_W'(1);
	end

	// width (low 12 bits of data) clamped to 3..MAX_WIDTH, height to at least 3; stored as last index
	always_comb begin
		fw = cfg_data[ssharp_pkg::FW_W-1:0];
		if (fw < ssharp_pkg::FW_W'(ssharp_pkg::MIN_DIM)) begin
			wlast_new = ssharp_pkg::COL_W'(ssharp_pkg::MIN_DIM - 1);
		end else if (fw > ssharp_pkg::FW_W'(ssharp_pkg::MAX_WIDTH)) begin
			wlast_new = ssharp_pkg::COL_W'(ssharp_pkg::MAX_WIDTH - 1);
		end else begin
			wlast_new = ssharp_pkg::COL_W'(fw - ssharp_pkg::FW_W'(1));
		end
		if (cfg_data < ssharp_pkg::CFG_DATA_W'(ssharp_pkg::MIN_DIM)) begin
			hlast_new = ssharp_pkg::ROW_W'(ssharp_pkg::MIN_DIM - 1);
		end else begin
			hlast_new = ssharp_pkg::ROW_W'(cfg_data - ssharp_pkg::CFG_DATA_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			wlast_q <= ssharp_pkg::COL_W'(ssharp_pkg::RST_WIDTH - 1);
			hlast_q <= ssharp_pkg::ROW_W'(ssharp_pkg::RST_HEIGHT - 1);
		end else if (cfg_we) begin
			// any register write restarts the frame
			case (ssharp_pkg::cfg_reg_t'(cfg_index))
				ssharp_pkg::REG_FRAME_WIDTH: begin
					wlast_q <= wlast_new;
					col_q   <= '0;
					row_q   <= '0;
				end
				ssharp_pkg::REG_FRAME_HEIGHT: begin
					hlast_q <= hlast_new;
					col_q   <= '0;
					row_q   <= '0;
				end
				default: begin
					col_q <= col_q;
				end
			endcase
		end else if (acc) begin
			if (col_q == wlast_q) begin
				col_q <= '0;
				row_q <= (row_q == hlast_q) ? '0 : row_q + ssharp_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + ssharp_pkg::COL_W'(1);
			end
		end
	end

	// memory is addressed by the current column, carried in tag.col + 1
	ssharp_pkg::tag_t tag_mem;
	always_comb begin
		tag_mem     = tag;
		tag_mem.col = col_q;
	end

	ssharp_pkg::tag_t tag_out_s2;

	ssharp_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.adv      (adv),
		.pixel    (pixel_in),
		.tag      (tag_mem),
		.valid_s2 (valid_s2),
		.tag_s2   (tag_s2),
		.win_q    (win_q)
	);

	always_comb begin
		tag_out_s2     = tag_s2;
		tag_out_s2.col = tag_s2.col - ssharp_pkg::COL_W'(1);
	end

	ssharp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.valid_s2   (valid_s2),
		.tag_s2     (tag_out_s2),
		.win_q      (win_q),
		.out_valid  (out_valid),
		.pixel_out  (pixel_out),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

endmodule
